/* rtl/led_matrix_row_scanner_assert.svh */
// Assertion macros shared by the LED matrix row scanner modules.
// Depends on nothing; the modules that check their logic take it in.
`ifndef LED_MATRIX_ROW_SCANNER_ASSERT_SVH
`define LED_MATRIX_ROW_SCANNER_ASSERT_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define LMRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lmrs: assertion failed");
// A condition that must be followed by another in the next cycle.
`define LMRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmrs: assertion failed");
`else
`define LMRS_ASSERT(lbl, clk, rst_n, prop)
`define LMRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/lmrs_pkg.sv */
// Types and constants of the LED matrix row scanner.
// Depends on nothing; used by every module of the block.
package lmrs_pkg;

  // Request field widths.
  localparam int MODE_W  = 2;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 3;
  localparam int CELL_W  = 8;
  localparam int LEVEL_W = 3;
  localparam int DWELL_W = 16;
  localparam int CNT_W   = 17;
  localparam int WORD_W  = 16;
  localparam int IN_TDATA_W = 24;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DWELL_TICKS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_LEVEL   = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [DWELL_W-1:0] DWELL_RESET     = 16'd500;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 3'd1;

  // Character code of the digit zero, the base of the level compare.
  localparam logic [CELL_W-1:0] DIGIT_ZERO = 8'h30;

  // Saturation value of the dwell counter.
  localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

  // Scan position handed from the sequencer to the frame store.
  typedef struct packed {
    logic               emit;
    logic [ROW_W-1:0]   row;
    logic [LEVEL_W-1:0] level;
  } scan_ctl_t;

endpackage

/* rtl/lmrs_frame.sv */
// Frame store of cell levels and the drive word builder.
// Depends on lmrs_pkg.
module lmrs_frame #(
  parameter int ROWS = 10,
  parameter int COLS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [lmrs_pkg::ROW_W-1:0]    wr_row_i,
  input  logic [lmrs_pkg::COL_W-1:0]    wr_col_i,
  input  logic [lmrs_pkg::CELL_W-1:0]   wr_value_i,
  input  lmrs_pkg::scan_ctl_t           ctl_i,
  output logic [lmrs_pkg::WORD_W-1:0]   word_o
);

  localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [lmrs_pkg::CELL_W-1:0] frame_q [ROWS][COLS];
  logic [RIDX_W-1:0]           rd_idx;
  logic [COLS-1:0]             hit;
  logic [lmrs_pkg::CELL_W:0]   thresh;
  logic [lmrs_pkg::WORD_W-1:0] word;

  // Cell write; a load outside the matrix matches no cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          frame_q[r][c] <= '0;
        end
      end
    end else begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          if (wr_en_i && (32'(wr_row_i) == r) && (32'(wr_col_i) == c)) begin
            frame_q[r][c] <= wr_value_i;
          end
        end
      end
    end
  end

  // Row select, guarded so that an out-of-range row reads row zero.
  assign rd_idx = (32'(ctl_i.row) < ROWS) ? RIDX_W'(ctl_i.row) : '0;
  assign thresh = {1'b0, lmrs_pkg::DIGIT_ZERO} + {{(lmrs_pkg::CELL_W-2){1'b0}}, ctl_i.level};

  // Column compare against the digit zero plus the current level.
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      hit[c] = {1'b0, frame_q[rd_idx][c]} > thresh;
    end
  end

  // Rows active low in the low bits, column zero at the top of the columns.
  always_comb begin
    for (int b = 0; b < lmrs_pkg::WORD_W; b++) begin
      if (b < ROWS) begin
        word[b] = (32'(rd_idx) != b);
      end else if ((b - ROWS) < COLS) begin
        word[b] = hit[COLS-1-(b-ROWS)];
      end else begin
        word[b] = 1'b0;
      end
    end
  end

  assign word_o = ctl_i.emit ? word : '0;

endmodule

/* rtl/lmrs_scan.sv */
// Scan sequencer: phase, row, level pass and dwell counter.
// Depends on lmrs_pkg and led_matrix_row_scanner_assert.svh.
`include "led_matrix_row_scanner_assert.svh"
module lmrs_scan #(
  parameter int ROWS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [lmrs_pkg::MODE_W-1:0]   mode_i,
  input  logic [lmrs_pkg::DWELL_W-1:0]  dwell_ticks_i,
  input  logic [lmrs_pkg::LEVEL_W-1:0]  max_level_i,
  output lmrs_pkg::scan_ctl_t           ctl_o,
  output logic                          idle_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NEW,
    PH_COMPUTE,
    PH_DWELL
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [lmrs_pkg::ROW_W-1:0]    scan_row_q, scan_row_d;
  logic [lmrs_pkg::LEVEL_W-1:0]  level_q, level_d;
  logic [lmrs_pkg::CNT_W-1:0]    dwell_q, dwell_d;
  logic [lmrs_pkg::CNT_W-1:0]    dwell_inc;
  logic                          emit;

  assign dwell_inc = (dwell_q == lmrs_pkg::CNT_MAX) ? dwell_q
                                                    : dwell_q + lmrs_pkg::CNT_W'(1);
  assign emit = step_i && (mode_i == lmrs_pkg::MODE_TICK) && (phase_q == PH_COMPUTE);

  // Next state for one processed request.
  always_comb begin
    phase_d    = phase_q;
    scan_row_d = scan_row_q;
    level_d    = level_q;
    dwell_d    = dwell_q;
    if (step_i) begin
      case (mode_i)
        lmrs_pkg::MODE_START: begin
          phase_d = PH_NEW;
        end
        lmrs_pkg::MODE_TICK: begin
          case (phase_q)
            PH_NEW: begin
              scan_row_d = '0;
              level_d    = '0;
              dwell_d    = '0;
              phase_d    = PH_COMPUTE;
            end
            PH_COMPUTE: begin
              dwell_d = '0;
              phase_d = PH_DWELL;
            end
            PH_DWELL: begin
              dwell_d = dwell_inc;
              if (dwell_inc > {1'b0, dwell_ticks_i}) begin
                phase_d = PH_COMPUTE;
                if (level_q >= max_level_i) begin
                  level_d = '0;
                  if (scan_row_q == lmrs_pkg::ROW_W'(ROWS - 1)) begin
                    scan_row_d = '0;
                    phase_d    = PH_IDLE;
                  end else begin
                    scan_row_d = scan_row_q + lmrs_pkg::ROW_W'(1);
                  end
                end else begin
                  level_d = level_q + lmrs_pkg::LEVEL_W'(1);
                end
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      scan_row_q <= '0;
      level_q    <= '0;
      dwell_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      scan_row_q <= scan_row_d;
      level_q    <= level_d;
      dwell_q    <= dwell_d;
    end
  end

  assign ctl_o.emit  = emit;
  assign ctl_o.row   = scan_row_q;
  assign ctl_o.level = level_q;
  assign idle_o      = (phase_d == PH_IDLE);

  // The scan position is cleared whenever the sequencer rests.
  `LMRS_ASSERT(a_idle_clear, clk_i, rst_ni, (phase_q != PH_IDLE) || ((scan_row_q == '0) && (level_q == '0)))
  // The scan row never leaves the matrix.
  `LMRS_ASSERT(a_row_range, clk_i, rst_ni, 32'(scan_row_q) < ROWS)
  // Every drive word is followed by a dwell.
  `LMRS_ASSERT_NEXT(a_emit_dwell, clk_i, rst_ni, emit, phase_q == PH_DWELL)

endmodule

/* rtl/led_matrix_row_scanner.sv */
// Top level of the LED matrix row scanner: request register, result register,
// configuration registers. Depends on lmrs_pkg, lmrs_frame, lmrs_scan and the
// assertion header.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: mode, cell_row, cell_col, cell_value
// m_axis    out  tvalid/tready          tdata: shift_word; tuser: word_valid, ready_res
// cfg       in   cfg_we_i, no wait      cfg_addr_i selects dwell_ticks or max_level
//
// One request is taken per cycle while m_axis does not stall; each gives one
// result, through the request register and then the result register.
// The frame store is read at one row and written at one cell per cycle.
// Reset returns the sequencer to idle and clears every cell to off.
// A stall at m_axis holds the result register, then the request register.
`include "led_matrix_row_scanner_assert.svh"
module led_matrix_row_scanner #(
  parameter int ROWS = 10,
  parameter int COLS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Stream in. tdata: mode[1:0], cell_row[5:2], cell_col[8:6], cell_value[16:9]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lmrs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Stream out. tdata: shift_word[15:0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lmrs_pkg::WORD_W-1:0]         m_axis_tdata,
  // tuser: word_valid[0], ready_res[1]
  output logic [1:0]                          m_axis_tuser,
  // Configuration writes.
  input  logic                                cfg_we_i,
  input  logic [lmrs_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [lmrs_pkg::DWELL_W-1:0]        cfg_wdata_i
);

  logic                            in_valid_q;
  logic [lmrs_pkg::MODE_W-1:0]     mode_q;
  logic [lmrs_pkg::ROW_W-1:0]      cell_row_q;
  logic [lmrs_pkg::COL_W-1:0]      cell_col_q;
  logic [lmrs_pkg::CELL_W-1:0]     cell_value_q;
  logic                            out_valid_q;
  logic [lmrs_pkg::WORD_W-1:0]     word_q;
  logic                            word_valid_q;
  logic                            ready_res_q;
  logic [lmrs_pkg::DWELL_W-1:0]    dwell_ticks_q;
  logic [lmrs_pkg::LEVEL_W-1:0]    max_level_q;
  logic                            advance;
  logic                            step_en;
  logic                            in_take;
  lmrs_pkg::scan_ctl_t             ctl;
  logic                            idle;
  logic [lmrs_pkg::WORD_W-1:0]     word;

  // The result register moves when empty or taken; the request register follows.
  assign advance       = !out_valid_q || m_axis_tready;
  assign step_en       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q <= lmrs_pkg::DWELL_RESET;
      max_level_q   <= lmrs_pkg::MAX_LEVEL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lmrs_pkg::CFG_DWELL_TICKS: dwell_ticks_q <= cfg_wdata_i;
        lmrs_pkg::CFG_MAX_LEVEL:   max_level_q   <= cfg_wdata_i[lmrs_pkg::LEVEL_W-1:0];
        default: begin
          dwell_ticks_q <= dwell_ticks_q;
        end
      endcase
    end
  end

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q       <= s_axis_tdata[1:0];
      cell_row_q   <= s_axis_tdata[5:2];
      cell_col_q   <= s_axis_tdata[8:6];
      cell_value_q <= s_axis_tdata[16:9];
    end
  end

  lmrs_scan #(
    .ROWS (ROWS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step_en),
    .mode_i        (mode_q),
    .dwell_ticks_i (dwell_ticks_q),
    .max_level_i   (max_level_q),
    .ctl_o         (ctl),
    .idle_o        (idle)
  );

  lmrs_frame #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (step_en && (mode_q == lmrs_pkg::MODE_LOAD)),
    .wr_row_i   (cell_row_q),
    .wr_col_i   (cell_col_q),
    .wr_value_i (cell_value_q),
    .ctl_i      (ctl),
    .word_o     (word)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      word_q       <= word;
      word_valid_q <= ctl.emit;
      ready_res_q  <= idle;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = word_q;
  assign m_axis_tuser  = {ready_res_q, word_valid_q};

  // A result without a drive word carries an all-zero word.
  `LMRS_ASSERT(a_word_zero, clk_i, rst_ni, !out_valid_q || word_valid_q || (word_q == '0))
  // A held request stays in the request register while the output stalls.
  `LMRS_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !advance, in_valid_q)
  // A result that is not taken stays offered.
  `LMRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !m_axis_tready, out_valid_q)

endmodule
